>>> rtl/core/ffsa_pkg.sv
// Shared types, constants and codes for the first-fit segment allocator.
// No dependencies; every module of the block imports this package.
`default_nettype none

package ffsa_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int ADDR_BITS    = 16;
    localparam int HEADER_BYTES = 24;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int POOL_RESET   = 4096;

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [IDX_W-1:0]     idx_t;

    localparam logic [31:0] ADDR_MAX32 = 32'((64'd1 << ADDR_BITS) - 64'd1);
    localparam addr_t HEADER = addr_t'(HEADER_BYTES);
    localparam addr_t RESET_SIZE = (POOL_RESET > HEADER_BYTES) ?
                                   addr_t'(POOL_RESET - HEADER_BYTES) : '0;
    localparam logic [15:0] POOL_RESET_16 = 16'(POOL_RESET);

    // one segment of the table
    typedef struct packed {
        logic  valid;
        logic  free;
        addr_t start;
        addr_t size;
    } entry_t;

    localparam entry_t EMPTY_ENTRY = '{valid: 1'b0, free: 1'b0, start: '0, size: '0};

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHR,
        CELL_SHL1,
        CELL_SHL2,
        CELL_INIT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   data;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        STAT_DONE       = 3'd0,
        STAT_TABLE_FULL = 3'd1,
        STAT_NO_FIT     = 3'd2,
        STAT_NULL_FREE  = 3'd3,
        STAT_UNKNOWN    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SEARCH,
        FSM_EXEC
    } fsm_t;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // saturate a written pool size to the address range
    function automatic logic [15:0] pool_clamp(input logic [15:0] value);
        logic [31:0] wide;
        wide = {16'b0, value};
        if (wide > ADDR_MAX32) begin
            wide = ADDR_MAX32;
        end
        return wide[15:0];
    endfunction

    // payload size of the single segment that covers a fresh pool
    function automatic addr_t pool_to_size(input logic [15:0] pool);
        logic [31:0] wide;
        wide = {16'b0, pool};
        if (wide > 32'(HEADER_BYTES)) begin
            return addr_t'(wide - 32'(HEADER_BYTES));
        end
        return '0;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/ffsa_cell.sv
// One cell of the segment chain: holds one table entry, shifts with its
// neighbors and flags a first-fit or address match. Depends on ffsa_pkg.
`default_nettype none

module ffsa_cell (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       is_head,
    input  wire ffsa_pkg::cell_ctrl_t ctrl,
    input  wire ffsa_pkg::entry_t     left_in,
    input  wire ffsa_pkg::entry_t     right1_in,
    input  wire ffsa_pkg::entry_t     right2_in,
    input  wire ffsa_pkg::addr_t      req,
    input  wire ffsa_pkg::addr_t      free_addr,
    output ffsa_pkg::entry_t          ent_out,
    output logic                      fit,
    output logic                      hit
);
    import ffsa_pkg::*;

    entry_t ent_reg;
    entry_t ent_next;

    always_comb begin
        ent_next = ent_reg;
        unique case (ctrl.op)
            CELL_HOLD: ent_next = ent_reg;
            CELL_LOAD: ent_next = ctrl.data;
            CELL_SHR:  ent_next = left_in;
            CELL_SHL1: ent_next = right1_in;
            CELL_SHL2: ent_next = right2_in;
            CELL_INIT: begin
                ent_next       = ctrl.data;
                ent_next.valid = is_head;
                ent_next.free  = is_head;
            end
            default:   ent_next = ent_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg.valid <= is_head;
            ent_reg.free  <= is_head;
            ent_reg.start <= '0;
            ent_reg.size  <= RESET_SIZE;
        end else begin
            ent_reg <= ent_next;
        end
    end

    assign ent_out = ent_reg;
    assign fit = ent_reg.valid && ent_reg.free && (ent_reg.size >= req);
    assign hit = ent_reg.valid &&
                 (({1'b0, ent_reg.start} + {1'b0, HEADER}) == {1'b0, free_addr});

endmodule

`default_nettype wire

>>> rtl/core/first_fit_segment_allocator_top.sv
// Top level of the first-fit segment allocator: command sequencer, cell
// chain, output register and APB register. Depends on ffsa_pkg, ffsa_cell.
// Sequence: an input transfer in the idle state, then a search state and an
// update state that registers the result. A new request is taken only in the
// idle state, after the update; an unaccepted result stalls only the update state.
// Reset: one free segment covering a 4096-byte pool, no clearing pass.
`default_nettype none

module first_fit_segment_allocator_top (
    input  wire         aclk,
    input  wire         aresetn,
    // s_tdata: request_size [15:0], free_address [31:16]
    input  wire  [31:0] s_tdata,
    // s_tuser: cmd [0]
    input  wire  [0:0]  s_tuser,
    input  wire         s_tvalid,
    output logic        s_tready,
    // m_tdata: payload_address [15:0]
    output logic [15:0] m_tdata,
    // m_tuser: status [2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ffsa_pkg::*;

    fsm_t        fsm_reg, fsm_next;
    logic        cmd_reg;
    addr_t       req_reg;
    addr_t       fa_reg;
    idx_t        idx_reg, idx_next;
    logic        found_reg, found_next;
    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;
    logic [15:0] pool_bytes_reg;

    entry_t      ent [MAX_SEGMENTS];
    entry_t      left_in [MAX_SEGMENTS];
    entry_t      right1_in [MAX_SEGMENTS];
    entry_t      right2_in [MAX_SEGMENTS];
    cell_ctrl_t  ctrl [MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] fit_vec;
    logic [MAX_SEGMENTS-1:0] hit_vec;
    logic [MAX_SEGMENTS-1:0] vld_vec;

    logic        cfg_we;
    logic [15:0] pool_new;
    logic        out_free;
    logic        in_xfer;
    logic        apply;

    // ---------------- cell chain ----------------
    for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
        if (k == 0) begin : g_l0
            assign left_in[k] = EMPTY_ENTRY;
        end else begin : g_l
            assign left_in[k] = ent[k-1];
        end
        if (k + 1 < MAX_SEGMENTS) begin : g_r1
            assign right1_in[k] = ent[k+1];
        end else begin : g_r1e
            assign right1_in[k] = EMPTY_ENTRY;
        end
        if (k + 2 < MAX_SEGMENTS) begin : g_r2
            assign right2_in[k] = ent[k+2];
        end else begin : g_r2e
            assign right2_in[k] = EMPTY_ENTRY;
        end

        ffsa_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .is_head   ((k == 0) ? 1'b1 : 1'b0),
            .ctrl      (ctrl[k]),
            .left_in   (left_in[k]),
            .right1_in (right1_in[k]),
            .right2_in (right2_in[k]),
            .req       (req_reg),
            .free_addr (fa_reg),
            .ent_out   (ent[k]),
            .fit       (fit_vec[k]),
            .hit       (hit_vec[k])
        );
        assign vld_vec[k] = ent[k].valid;
    end

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign pool_new = pool_clamp(pwdata[15:0]);
    assign prdata   = (paddr[2] == 1'b0) ? {16'b0, pool_bytes_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_bytes_reg <= pool_clamp(POOL_RESET_16);
        end else if (cfg_we) begin
            pool_bytes_reg <= pool_new;
        end
    end

    // ---------------- sequencer ----------------
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (fsm_reg == FSM_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign apply    = (fsm_reg == FSM_EXEC) && out_free && found_reg;

    always_comb begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            FSM_IDLE:   if (s_tvalid) fsm_next = FSM_SEARCH;
            FSM_SEARCH: fsm_next = FSM_EXEC;
            FSM_EXEC:   if (out_free) fsm_next = FSM_IDLE;
            default:    fsm_next = FSM_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg <= FSM_IDLE;
        end else begin
            fsm_reg <= fsm_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            cmd_reg <= s_tuser[0];
            req_reg <= addr_t'(s_tdata[15:0]);
            fa_reg  <= addr_t'(s_tdata[31:16]);
        end
    end

    // first hit (free) or fit (alloc) from the low end of the chain
    always_comb begin
        logic [MAX_SEGMENTS-1:0] sel;
        sel        = (cmd_reg == CMD_FREE) ? hit_vec : fit_vec;
        found_next = |sel;
        idx_next   = '0;
        for (int k = MAX_SEGMENTS - 1; k >= 0; k--) begin
            if (sel[k]) begin
                idx_next = idx_t'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fsm_reg == FSM_SEARCH) begin
            idx_reg   <= idx_next;
            found_reg <= found_next;
        end
    end

    // ---------------- update and result ----------------
    entry_t      ent_f, ent_l, ent_r;
    logic        split_want, full, do_split;
    logic        merge_l, merge_r;
    idx_t        base_idx;
    addr_t       merged_size;
    addr_t       base_start;
    logic [15:0] res_addr;
    status_t     res_status;

    always_comb begin
        ent_f = ent[idx_reg];
        ent_l = (idx_reg != idx_t'(0)) ? ent[idx_reg - idx_t'(1)] : EMPTY_ENTRY;
        ent_r = (idx_reg != idx_t'(MAX_SEGMENTS - 1)) ? ent[idx_reg + idx_t'(1)]
                                                      : EMPTY_ENTRY;

        split_want = ({1'b0, ent_f.size} > ({1'b0, req_reg} + {1'b0, HEADER}));
        full       = ent[MAX_SEGMENTS-1].valid;
        do_split   = split_want && !full;

        merge_l  = (idx_reg != idx_t'(0)) && ent_l.valid && ent_l.free;
        merge_r  = ent_r.valid && ent_r.free;
        base_idx = merge_l ? (idx_reg - idx_t'(1)) : idx_reg;
        base_start  = merge_l ? ent_l.start : ent_f.start;
        merged_size = ent_f.size
                    + (merge_l ? (ent_l.size + HEADER) : addr_t'(0))
                    + (merge_r ? (ent_r.size + HEADER) : addr_t'(0));

        res_addr   = '0;
        res_status = STAT_DONE;
        if (cmd_reg == CMD_ALLOC) begin
            if (found_reg) begin
                res_addr   = 16'(ent_f.start + HEADER);
                res_status = (split_want && full) ? STAT_TABLE_FULL : STAT_DONE;
            end else begin
                res_status = STAT_NO_FIT;
            end
        end else if (fa_reg == '0) begin
            res_status = STAT_NULL_FREE;
        end else if (!found_reg) begin
            res_status = STAT_UNKNOWN;
        end
    end

    always_comb begin
        int ki;
        int kb;
        for (int k = 0; k < MAX_SEGMENTS; k++) begin
            ctrl[k].op   = CELL_HOLD;
            ctrl[k].data = ent[k];
        end
        ki = int'(idx_reg);
        kb = int'(base_idx);
        if (cfg_we) begin
            for (int k = 0; k < MAX_SEGMENTS; k++) begin
                ctrl[k].op         = CELL_INIT;
                ctrl[k].data.valid = 1'b1;
                ctrl[k].data.free  = 1'b1;
                ctrl[k].data.start = '0;
                ctrl[k].data.size  = pool_to_size(pool_new);
            end
        end else if (apply && (cmd_reg == CMD_ALLOC)) begin
            for (int k = 0; k < MAX_SEGMENTS; k++) begin
                if (k == ki) begin
                    ctrl[k].op         = CELL_LOAD;
                    ctrl[k].data       = ent_f;
                    ctrl[k].data.free  = 1'b0;
                    ctrl[k].data.size  = do_split ? req_reg : ent_f.size;
                end else if (do_split && (k == ki + 1)) begin
                    // split remainder lands right after the granted segment
                    ctrl[k].op         = CELL_LOAD;
                    ctrl[k].data.valid = 1'b1;
                    ctrl[k].data.free  = 1'b1;
                    ctrl[k].data.start = ent_f.start + HEADER + req_reg;
                    ctrl[k].data.size  = ent_f.size - req_reg - HEADER;
                end else if (do_split && (k > ki + 1)) begin
                    ctrl[k].op = CELL_SHR;
                end
            end
        end else if (apply) begin
            for (int k = 0; k < MAX_SEGMENTS; k++) begin
                if (k == kb) begin
                    ctrl[k].op         = CELL_LOAD;
                    ctrl[k].data.valid = 1'b1;
                    ctrl[k].data.free  = 1'b1;
                    ctrl[k].data.start = base_start;
                    ctrl[k].data.size  = merged_size;
                end else if (k > kb) begin
                    if (merge_l && merge_r) begin
                        ctrl[k].op = CELL_SHL2;
                    end else if (merge_l || merge_r) begin
                        ctrl[k].op = CELL_SHL1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((fsm_reg == FSM_EXEC) && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((fsm_reg == FSM_EXEC) && out_free) begin
            m_tdata_reg <= res_addr;
            m_tuser_reg <= 3'(res_status);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- assertions ----------------
    logic prefix_ok;
    assign prefix_ok = (((vld_vec >> 1) & ~vld_vec) == '0);

    a_prefix: assert property (@(posedge aclk) disable iff (!aresetn) prefix_ok)
        else $error("segment table has a hole");

    a_head: assert property (@(posedge aclk) disable iff (!aresetn) vld_vec[0])
        else $error("segment table lost its first entry");

    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (fsm_reg == FSM_EXEC) && out_free |=> m_tvalid_reg)
        else $error("update cycle did not present a result");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tuser_reg <= 3'(STAT_UNKNOWN)))
        else $error("status code out of range");

endmodule

`default_nettype wire
